// ===== rtl/lom_pkg.sv =====
// Shared types and constants for the load overcurrent monitor.
// No dependencies; every other file refers to this package by scoped names.
package lom_pkg;

    // Sample path width. The low registers reset to all ones at LOW_BITS.
    localparam int SAMPLE_BITS = 10;
    localparam int LOW_BITS    = 16;
    localparam int OUT_BITS    = 10;

    localparam logic [LOW_BITS-1:0] LOW_RESET = 16'hFFFF;

    localparam logic [4:0] COUNT_MAX   = 5'd20;
    localparam logic [4:0] EARLY_LIMIT = 5'd5;
    localparam logic [4:0] SAFE_AFTER  = 5'd15;

    // Command codes of an input word.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Error cause codes.
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_EARLY  = 2'd1;
    localparam logic [1:0] CAUSE_REPEAT = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_BITS  = 2;
    localparam int          CFG_DATA_BITS = 14;
    localparam logic [1:0]  REG_STEADY_THR  = 2'd0;
    localparam logic [1:0]  REG_STARTUP_THR = 2'd1;
    localparam logic [1:0]  REG_WINDOW      = 2'd2;
    localparam logic [1:0]  REG_HOLD        = 2'd3;

    localparam logic [9:0]  RST_STEADY_THR  = 10'd600;
    localparam logic [9:0]  RST_STARTUP_THR = 10'd600;
    localparam logic [5:0]  RST_WINDOW      = 6'd32;
    localparam logic [13:0] RST_HOLD        = 14'd10000;

    // Queue depth; must be a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Classified input word as it waits between front and back.
    typedef struct packed {
        logic       is_tick;
        logic [9:0] sample;
        logic       lamp_request;
        logic       temp_ok;
    } t_item;

    typedef struct packed {
        logic       overload_fault;
        logic       safe;
        logic [1:0] error_cause;
        logic [9:0] peak_to_peak;
        logic [9:0] steady_load;
        logic [4:0] window_number;
        logic       window_done;
        logic       error_led;
        logic       measuring;
    } t_result;

    // Handshake between a queue and the stage that drains it.
    typedef struct packed {
        logic valid;
        logic take;
    } t_link;

endpackage

// ===== rtl/load_overcurrent_monitor.sv =====
// Load overcurrent monitor: front queue, single-cycle execute stage, result queue.
// Each accepted word passes the execute stage and is registered in the result queue.
// Throughput: one word per cycle while a word waits and the result queue is not full.
// Each side stalls on its own behind a two-entry queue.
// Reset (synchronous, active low) empties both queues, restores the monitor state
// and loads the default configuration; no clearing pass, the block is ready at once.
module load_overcurrent_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lom_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lom_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_command,
    input  logic [9:0]                          i_sample,
    input  logic                                i_lamp_request,
    input  logic                                i_temp_ok,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_overload_fault,
    output logic                                o_safe,
    output logic [1:0]                          o_error_cause,
    output logic [9:0]                          o_peak_to_peak,
    output logic [9:0]                          o_steady_load,
    output logic [4:0]                          o_window_number,
    output logic                                o_window_done,
    output logic                                o_error_led,
    output logic                                o_measuring
);

    lom_pkg::t_item    item;
    logic              item_valid;
    lom_pkg::t_link    link;
    lom_pkg::t_result  result_in;
    lom_pkg::t_result  result_out;
    logic              res_full;

    lom_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_sample       (i_sample),
        .i_lamp_request (i_lamp_request),
        .i_temp_ok      (i_temp_ok),
        .i_take         (link.take),
        .o_valid        (item_valid),
        .o_item         (item)
    );

    lom_exec u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (item),
        .i_item_valid (item_valid),
        .i_res_full   (res_full),
        .o_link       (link),
        .o_result     (result_in)
    );

    lom_result_queue u_result_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (link),
        .i_result (result_in),
        .o_full   (res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (result_out)
    );

    assign o_overload_fault = result_out.overload_fault;
    assign o_safe           = result_out.safe;
    assign o_error_cause    = result_out.error_cause;
    assign o_peak_to_peak   = result_out.peak_to_peak;
    assign o_steady_load    = result_out.steady_load;
    assign o_window_number  = result_out.window_number;
    assign o_window_done    = result_out.window_done;
    assign o_error_led      = result_out.error_led;
    assign o_measuring      = result_out.measuring;

endmodule

// ===== rtl/lom_front.sv =====
// Front end: accepts input words, classifies the command and queues them.
// Depends on lom_pkg.
module lom_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic             i_command,
    input  logic [9:0]       i_sample,
    input  logic             i_lamp_request,
    input  logic             i_temp_ok,
    input  logic             i_take,
    output logic             o_valid,
    output lom_pkg::t_item   o_item
);

    lom_pkg::t_item                   r_mem [lom_pkg::QUEUE_DEPTH];
    logic [lom_pkg::PTR_BITS-1:0]     r_wr_ptr;
    logic [lom_pkg::PTR_BITS-1:0]     r_rd_ptr;
    logic [lom_pkg::CNT_BITS-1:0]     r_count;
    logic                             wr_en;
    logic                             rd_en;
    lom_pkg::t_item                   item_in;

    assign full    = (r_count == lom_pkg::CNT_BITS'(lom_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        item_in.is_tick      = (i_command == lom_pkg::CMD_TICK);
        item_in.sample       = i_sample;
        item_in.lamp_request = i_lamp_request;
        item_in.temp_ok      = i_temp_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + lom_pkg::CNT_BITS'(wr_en) - lom_pkg::CNT_BITS'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

endmodule

// ===== rtl/lom_exec.sv =====
// Back end: holds config and monitor state; applies one word per cycle unless stalled.
// Depends on lom_pkg.
module lom_exec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lom_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lom_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  lom_pkg::t_item                      i_item,
    input  logic                                i_item_valid,
    input  logic                                i_res_full,
    output lom_pkg::t_link                      o_link,
    output lom_pkg::t_result                    o_result
);

    // configuration
    logic [9:0]  r_steady_thr;
    logic [9:0]  r_startup_thr;
    logic [5:0]  r_window_ticks;
    logic [13:0] r_hold_ticks;

    // monitor state
    logic [lom_pkg::SAMPLE_BITS-1:0] r_high0, r_high1, n_high0, n_high1;
    logic [lom_pkg::LOW_BITS-1:0]    r_low0, r_low1, n_low0, n_low1;
    logic [5:0]  r_window_timer, n_window_timer;
    logic [13:0] r_hold_timer, n_hold_timer;
    logic [4:0]  r_window_count, n_window_count;
    logic [1:0]  r_excess, n_excess;
    logic [9:0]  r_active_thr, n_active_thr;
    logic [lom_pkg::SAMPLE_BITS-1:0] r_amplitude, n_amplitude;
    logic [lom_pkg::SAMPLE_BITS-1:0] r_accepted, n_accepted;
    logic [1:0]  r_cause, n_cause;
    logic r_error, n_error;
    logic r_safe, n_safe;
    logic r_lamp_on, n_lamp_on;
    logic r_sampling, n_sampling;
    logic r_led, n_led;

    logic                            fire;
    logic                            done;
    logic [lom_pkg::SAMPLE_BITS-1:0] s;
    logic [lom_pkg::LOW_BITS-1:0]    s_wide;
    logic [14:0]                     hold_inc;
    logic [6:0]                      window_inc;
    logic [lom_pkg::LOW_BITS-1:0]    spread;

    assign fire        = i_item_valid && !i_res_full;
    assign o_link.valid = fire;
    assign o_link.take  = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steady_thr   <= lom_pkg::RST_STEADY_THR;
            r_startup_thr  <= lom_pkg::RST_STARTUP_THR;
            r_window_ticks <= lom_pkg::RST_WINDOW;
            r_hold_ticks   <= lom_pkg::RST_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lom_pkg::REG_STEADY_THR:  r_steady_thr   <= i_cfg_data[9:0];
                lom_pkg::REG_STARTUP_THR: r_startup_thr  <= i_cfg_data[9:0];
                lom_pkg::REG_WINDOW:      r_window_ticks <= i_cfg_data[5:0];
                lom_pkg::REG_HOLD:        r_hold_ticks   <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_high0        = r_high0;
        n_high1        = r_high1;
        n_low0         = r_low0;
        n_low1         = r_low1;
        n_window_timer = r_window_timer;
        n_hold_timer   = r_hold_timer;
        n_window_count = r_window_count;
        n_excess       = r_excess;
        n_active_thr   = r_active_thr;
        n_amplitude    = r_amplitude;
        n_accepted     = r_accepted;
        n_cause        = r_cause;
        n_error        = r_error;
        n_safe         = r_safe;
        n_lamp_on      = r_lamp_on;
        n_sampling     = r_sampling;
        n_led          = r_led;
        done           = 1'b0;
        s              = lom_pkg::SAMPLE_BITS'(i_item.sample);
        s_wide         = lom_pkg::LOW_BITS'(s);
        hold_inc       = 15'(r_hold_timer) + 15'd1;
        window_inc     = 7'(r_window_timer) + 7'd1;
        spread         = lom_pkg::LOW_BITS'(r_high1) - r_low1;

        if (!i_item.is_tick) begin
            // cascade: first register that the sample beats takes it
            if (r_sampling) begin
                priority if (r_high0 < s) begin
                    n_high0 = s;
                end else if (r_high1 < s) begin
                    n_high1 = s;
                end else if (r_low0 > s_wide) begin
                    n_low0 = s_wide;
                end else if (r_low1 > s_wide) begin
                    n_low1 = s_wide;
                end else begin
                    // inside all four bounds: hold
                    n_high0 = r_high0;
                end
            end
        end else begin
            if (r_error) begin
                if (hold_inc >= 15'(r_hold_ticks)) begin
                    n_hold_timer = '0;
                    n_error      = 1'b0;
                    n_safe       = 1'b1;
                end else begin
                    n_hold_timer = hold_inc[13:0];
                end
            end
            if (r_sampling) begin
                if (window_inc >= 7'(r_window_ticks)) begin
                    n_window_timer = '0;
                    n_sampling     = 1'b0;
                    done           = 1'b1;
                    // judge the window only when it shows a real spread
                    if (lom_pkg::LOW_BITS'(r_high1) > r_low1) begin
                        n_amplitude = lom_pkg::SAMPLE_BITS'(spread);
                        if (r_window_count < lom_pkg::COUNT_MAX) begin
                            n_window_count = r_window_count + 5'd1;
                            n_active_thr   = (n_window_count == lom_pkg::EARLY_LIMIT)
                                             ? r_steady_thr : r_startup_thr;
                        end
                        if (lom_pkg::LOW_BITS'(n_amplitude) >
                            lom_pkg::LOW_BITS'(n_active_thr)) begin
                            if (n_window_count < lom_pkg::EARLY_LIMIT) begin
                                n_error = 1'b1;
                                n_safe  = 1'b0;
                                n_cause = lom_pkg::CAUSE_EARLY;
                            end else if (r_excess >= 2'd2) begin
                                n_excess = '0;
                                n_error  = 1'b1;
                                n_safe   = 1'b0;
                                n_cause  = lom_pkg::CAUSE_REPEAT;
                            end else begin
                                n_excess = r_excess + 2'd1;
                            end
                        end else begin
                            n_excess = '0;
                            if (n_window_count > lom_pkg::EARLY_LIMIT) begin
                                n_accepted = n_amplitude;
                            end
                            if (n_window_count > lom_pkg::SAFE_AFTER) begin
                                n_safe = 1'b1;
                            end
                        end
                    end
                    n_high0 = '0;
                    n_high1 = '0;
                    n_low0  = lom_pkg::LOW_RESET;
                    n_low1  = lom_pkg::LOW_RESET;
                end else begin
                    n_window_timer = window_inc[5:0];
                end
            end else if (i_item.lamp_request) begin
                if (!r_lamp_on) begin
                    n_lamp_on = 1'b1;
                    n_safe    = 1'b0;
                    n_led     = 1'b0;
                end
                if (i_item.temp_ok) begin
                    n_sampling = 1'b1;
                end
            end else if (r_lamp_on) begin
                // lamp off: drop the counts and show the indicator
                n_lamp_on      = 1'b0;
                n_excess       = '0;
                n_window_count = '0;
                n_accepted     = '0;
                n_high0        = '0;
                n_high1        = '0;
                n_low0         = lom_pkg::LOW_RESET;
                n_low1         = lom_pkg::LOW_RESET;
                n_led          = 1'b1;
                if (!n_error) begin
                    n_safe = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_result.overload_fault = n_error;
        o_result.safe           = n_safe;
        o_result.error_cause    = n_cause;
        o_result.peak_to_peak   = lom_pkg::OUT_BITS'(n_amplitude);
        o_result.steady_load    = lom_pkg::OUT_BITS'(n_accepted);
        o_result.window_number  = n_window_count;
        o_result.window_done    = done;
        o_result.error_led      = n_led;
        o_result.measuring      = n_sampling;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high0        <= '0;
            r_high1        <= '0;
            r_low0         <= lom_pkg::LOW_RESET;
            r_low1         <= lom_pkg::LOW_RESET;
            r_window_timer <= '0;
            r_hold_timer   <= '0;
            r_window_count <= '0;
            r_excess       <= '0;
            r_active_thr   <= '0;
            r_amplitude    <= '0;
            r_accepted     <= '0;
            r_cause        <= lom_pkg::CAUSE_NONE;
            r_error        <= 1'b0;
            r_safe         <= 1'b1;
            r_lamp_on      <= 1'b0;
            r_sampling     <= 1'b0;
            r_led          <= 1'b0;
        end else if (fire) begin
            r_high0        <= n_high0;
            r_high1        <= n_high1;
            r_low0         <= n_low0;
            r_low1         <= n_low1;
            r_window_timer <= n_window_timer;
            r_hold_timer   <= n_hold_timer;
            r_window_count <= n_window_count;
            r_excess       <= n_excess;
            r_active_thr   <= n_active_thr;
            r_amplitude    <= n_amplitude;
            r_accepted     <= n_accepted;
            r_cause        <= n_cause;
            r_error        <= n_error;
            r_safe         <= n_safe;
            r_lamp_on      <= n_lamp_on;
            r_sampling     <= n_sampling;
            r_led          <= n_led;
        end
    end

endmodule

// ===== rtl/lom_result_queue.sv =====
// Result queue: holds finished result words until the consumer pops them.
// Depends on lom_pkg.
module lom_result_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lom_pkg::t_link     i_link,
    input  lom_pkg::t_result   i_result,
    output logic               o_full,
    output logic               empty,
    input  logic               pop,
    output lom_pkg::t_result   o_result
);

    lom_pkg::t_result                 r_mem [lom_pkg::QUEUE_DEPTH];
    logic [lom_pkg::PTR_BITS-1:0]     r_wr_ptr;
    logic [lom_pkg::PTR_BITS-1:0]     r_rd_ptr;
    logic [lom_pkg::CNT_BITS-1:0]     r_count;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full   = (r_count == lom_pkg::CNT_BITS'(lom_pkg::QUEUE_DEPTH));
    assign empty    = (r_count == '0);
    // the back end only offers a word when there is room
    assign wr_en    = i_link.valid && !o_full;
    assign rd_en    = pop && !empty;
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + lom_pkg::CNT_BITS'(wr_en) - lom_pkg::CNT_BITS'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule
